@@ hw/rtl/dvk_pkg.sv @@
// Shared types, address map and micro-program for the decaying-velocity tracking filter.
`default_nettype none

package dvk_pkg;

	localparam int DATA_W        = 32;
	localparam int WIDE_W        = 66;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ADDR_W        = 6;
	localparam int MEM_DEPTH     = 1 << ADDR_W;
	localparam int PC_W          = 8;
	localparam int CFG_ADDR_W    = 3;

	// Register file map.
	localparam int X_BASE = 0;
	localparam int P_BASE = 4;
	localparam int A_BASE = 20;
	localparam int K_BASE = 36;
	localparam int R_YX   = 44;
	localparam int R_YY   = 45;
	localparam int R_S00  = 46;
	localparam int R_S11  = 47;
	localparam int R_DET  = 48;
	localparam int R_T1   = 49;
	localparam int R_T2   = 50;

	// Program entry points.
	localparam int INIT_BASE = 0;
	localparam int PRED_BASE = 20;
	localparam int UPD_BASE  = 59;
	localparam int EPI_BASE  = 198;

	// Command codes on the input channel.
	localparam logic [1:0] CMD_INIT    = 2'd0;
	localparam logic [1:0] CMD_PREDICT = 2'd1;
	localparam logic [1:0] CMD_UPDATE  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] CFG_DECAY = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_QN    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_RN    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_IPV   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_IVV   = 3'd4;

	typedef enum logic [3:0] {
		OP_LDC, OP_ADD, OP_SUB, OP_MOV, OP_MUL, OP_AMUL, OP_DIV, OP_BRZ, OP_OUTP, OP_OUTV
	} op_t;

	typedef enum logic [2:0] {
		CS_ZERO, CS_MX, CS_MY, CS_QN, CS_RN, CS_IPV, CS_IVV
	} csel_t;

	typedef struct packed {
		op_t               opc;
		logic [ADDR_W-1:0] ra;
		logic [ADDR_W-1:0] rb;
		logic [ADDR_W-1:0] wd;
		csel_t             cs;
		logic              last;
		logic              fin;
	} uop_t;

	typedef struct packed {
		logic cap;
		logic rd;
		logic ex;
		logic wb;
		logic div_go;
		logic out_load;
		uop_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic a_zero;
		logic div_done;
	} dp_stat_t;

	function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(32'sh7FFF_FFFF);
		lo = -WIDE_W'(33'sh0_8000_0000);
		if (v > hi) return 32'sh7FFF_FFFF;
		if (v < lo) return 32'sh8000_0000;
		return v[DATA_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] ad(input int a);
		return ADDR_W'(a);
	endfunction

	// One micro-operation per program counter value.
	function automatic uop_t prog(input logic [PC_W-1:0] pc);
		uop_t u;
		int   n, e, g, k, s, i, j, c;
		u = '{opc: OP_MOV, ra: '0, rb: '0, wd: '0, cs: CS_ZERO, last: 1'b0, fin: 1'b0};
		n = int'(pc);
		if (n < PRED_BASE) begin
			e = n - INIT_BASE;
			u.opc = OP_LDC;
			if (e < 4) begin
				u.wd = ad(X_BASE + e);
				u.cs = (e == 0) ? CS_MX : ((e == 1) ? CS_MY : CS_ZERO);
			end else begin
				k = e - 4;
				u.wd = ad(P_BASE + k);
				u.cs = (k == 0 || k == 5) ? CS_IPV : ((k == 10 || k == 15) ? CS_IVV : CS_ZERO);
				u.last = (k == 15);
			end
		end else if (n < UPD_BASE) begin
			e = n - PRED_BASE;
			if (e < 2) begin
				u.opc = OP_ADD; u.ra = ad(X_BASE + e); u.rb = ad(X_BASE + e + 2);
				u.wd = ad(X_BASE + e);
			end else if (e < 4) begin
				u.opc = OP_AMUL; u.ra = ad(X_BASE + e); u.wd = ad(X_BASE + e);
			end else if (e < 20) begin
				k = e - 4;
				i = k / 4;
				u.wd = ad(A_BASE + k);
				u.ra = ad(P_BASE + k);
				if (i < 2) begin
					u.opc = OP_ADD; u.rb = ad(P_BASE + k + 8);
				end else begin
					u.opc = OP_AMUL;
				end
			end else if (e < 36) begin
				k = e - 20;
				j = k % 4;
				u.wd = ad(P_BASE + k);
				u.ra = ad(A_BASE + k);
				if (j < 2) begin
					u.opc = OP_ADD; u.rb = ad(A_BASE + k + 2);
				end else begin
					u.opc = OP_AMUL;
				end
			end else if (e == 36) begin
				u.opc = OP_LDC; u.cs = CS_QN; u.wd = ad(R_T1);
			end else begin
				k = (e == 37) ? 10 : 15;
				u.opc = OP_ADD; u.ra = ad(P_BASE + k); u.rb = ad(R_T1);
				u.wd = ad(P_BASE + k);
				u.last = (e == 38);
			end
		end else if (n < EPI_BASE) begin
			e = n - UPD_BASE;
			if (e < 11) begin
				case (e)
					0: begin u.opc = OP_LDC; u.cs = CS_MX; u.wd = ad(R_T1); end
					1: begin u.opc = OP_SUB; u.ra = ad(R_T1); u.rb = ad(X_BASE); u.wd = ad(R_YX); end
					2: begin u.opc = OP_LDC; u.cs = CS_MY; u.wd = ad(R_T1); end
					3: begin
						u.opc = OP_SUB; u.ra = ad(R_T1); u.rb = ad(X_BASE + 1); u.wd = ad(R_YY);
					end
					4: begin u.opc = OP_LDC; u.cs = CS_RN; u.wd = ad(R_T1); end
					5: begin u.opc = OP_ADD; u.ra = ad(P_BASE); u.rb = ad(R_T1); u.wd = ad(R_S00); end
					6: begin
						u.opc = OP_ADD; u.ra = ad(P_BASE + 5); u.rb = ad(R_T1); u.wd = ad(R_S11);
					end
					7: begin u.opc = OP_MUL; u.ra = ad(R_S00); u.rb = ad(R_S11); u.wd = ad(R_T1); end
					8: begin
						u.opc = OP_MUL; u.ra = ad(P_BASE + 1); u.rb = ad(P_BASE + 4); u.wd = ad(R_T2);
					end
					9: begin u.opc = OP_SUB; u.ra = ad(R_T1); u.rb = ad(R_T2); u.wd = ad(R_DET); end
					default: begin u.opc = OP_BRZ; u.ra = ad(R_DET); end
				endcase
			end else if (e < 43) begin
				g = e - 11; k = g / 4; s = g % 4; i = k / 2; c = k % 2;
				case (s)
					0: begin
						u.opc = OP_MUL; u.ra = ad(P_BASE + i * 4 + c);
						u.rb = (c == 1) ? ad(R_S00) : ad(R_S11); u.wd = ad(R_T1);
					end
					1: begin
						u.opc = OP_MUL; u.ra = ad(P_BASE + i * 4 + 1 - c);
						u.rb = (c == 1) ? ad(P_BASE + 1) : ad(P_BASE + 4); u.wd = ad(R_T2);
					end
					2: begin u.opc = OP_SUB; u.ra = ad(R_T1); u.rb = ad(R_T2); u.wd = ad(R_T1); end
					default: begin
						u.opc = OP_DIV; u.ra = ad(R_T1); u.rb = ad(R_DET); u.wd = ad(K_BASE + k);
					end
				endcase
			end else if (e < 59) begin
				g = e - 43; i = g / 4; s = g % 4;
				case (s)
					0: begin u.opc = OP_MUL; u.ra = ad(K_BASE + 2 * i); u.rb = ad(R_YX); u.wd = ad(R_T1); end
					1: begin
						u.opc = OP_MUL; u.ra = ad(K_BASE + 2 * i + 1); u.rb = ad(R_YY); u.wd = ad(R_T2);
					end
					2: begin u.opc = OP_ADD; u.ra = ad(R_T1); u.rb = ad(R_T2); u.wd = ad(R_T1); end
					default: begin
						u.opc = OP_ADD; u.ra = ad(X_BASE + i); u.rb = ad(R_T1); u.wd = ad(X_BASE + i);
					end
				endcase
			end else if (e < 123) begin
				g = e - 59; k = g / 4; s = g % 4; i = k / 4; j = k % 4;
				case (s)
					0: begin
						u.opc = OP_MUL; u.ra = ad(K_BASE + 2 * i); u.rb = ad(P_BASE + j); u.wd = ad(R_T1);
					end
					1: begin
						u.opc = OP_MUL; u.ra = ad(K_BASE + 2 * i + 1); u.rb = ad(P_BASE + 4 + j);
						u.wd = ad(R_T2);
					end
					2: begin u.opc = OP_ADD; u.ra = ad(R_T1); u.rb = ad(R_T2); u.wd = ad(R_T1); end
					default: begin
						u.opc = OP_SUB; u.ra = ad(P_BASE + k); u.rb = ad(R_T1); u.wd = ad(A_BASE + k);
					end
				endcase
			end else begin
				k = e - 123;
				u.opc = OP_MOV; u.ra = ad(A_BASE + k); u.wd = ad(P_BASE + k);
				u.last = (k == 15);
			end
		end else begin
			e = n - EPI_BASE;
			if (e == 0) begin
				u.opc = OP_OUTP; u.ra = ad(X_BASE); u.rb = ad(X_BASE + 1);
			end else begin
				u.opc = OP_OUTV; u.ra = ad(P_BASE); u.rb = ad(P_BASE + 5); u.fin = 1'b1;
			end
		end
		return u;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dvk_div.sv @@
// Iterative restoring divider for the gain terms, one quotient bit per cycle.
`default_nettype none

module dvk_div
	import dvk_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic signed [DATA_W-1:0]   num,
	input  wire logic signed [DATA_W-1:0]   den,
	output logic                            done,
	output logic                            neg,
	output logic [DATA_W+FRAC_BITS-1:0]     quot
);

	localparam int NW = DATA_W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]     dvd_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              neg_q;

	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_sub;
	logic              qbit;
	logic [DATA_W:0]   num_w;
	logic [DATA_W:0]   den_w;

	assign num_w   = num[DATA_W-1] ? -{num[DATA_W-1], num} : {1'b0, num};
	assign den_w   = den[DATA_W-1] ? -{den[DATA_W-1], den} : {1'b0, den};
	assign rem_sh  = {rem_q, dvd_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign qbit    = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_w[DATA_W-1:0], {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= den_w[DATA_W-1:0];
			neg_q <= num[DATA_W-1] ^ den[DATA_W-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NW-2:0], qbit};
			rem_q <= qbit ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
		end
	end

	assign done = done_q;
	assign neg  = neg_q;
	assign quot = dvd_q;

endmodule

`default_nettype wire

@@ hw/rtl/dvk_ctrl.sv @@
// Sequencer that steps the micro-program for each command and runs the channel handshakes.
`default_nettype none

module dvk_ctrl
	import dvk_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic [1:0] cmd,
	output logic          out_valid,
	input  wire logic     out_ready,
	output dp_cmd_t       dcmd,
	input  dp_stat_t      dstat
);

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_EXEC, S_DIVW, S_WBACK, S_FIN
	} state_t;

	state_t          state_q;
	logic [PC_W-1:0] pc_q;
	logic            out_valid_q;
	uop_t            op;
	logic            writes;
	logic [PC_W-1:0] pc_adv;
	logic            load_ok;

	assign op      = prog(pc_q);
	assign pc_adv  = op.last ? PC_W'(EPI_BASE) : pc_q + 1'b1;
	assign load_ok = !out_valid_q || out_ready;

	always_comb begin
		case (op.opc)
			OP_LDC, OP_ADD, OP_SUB, OP_MOV, OP_MUL, OP_AMUL: writes = 1'b1;
			default: writes = 1'b0;
		endcase
	end

	always_comb begin
		dcmd          = '0;
		dcmd.op       = op;
		dcmd.cap      = (state_q == S_IDLE) && in_valid;
		dcmd.rd       = (state_q == S_FETCH);
		dcmd.ex       = (state_q == S_EXEC);
		dcmd.div_go   = (state_q == S_EXEC) && (op.opc == OP_DIV);
		dcmd.wb       = (state_q == S_WBACK);
		dcmd.out_load = (state_q == S_FIN) && load_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (cmd)
							CMD_INIT:    pc_q <= PC_W'(INIT_BASE);
							CMD_PREDICT: pc_q <= PC_W'(PRED_BASE);
							CMD_UPDATE:  pc_q <= PC_W'(UPD_BASE);
							default:     pc_q <= PC_W'(EPI_BASE);
						endcase
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_EXEC;
				S_EXEC: begin
					if (op.opc == OP_DIV) begin
						state_q <= S_DIVW;
					end else if (writes) begin
						state_q <= S_WBACK;
					end else if (op.fin) begin
						state_q <= S_FIN;
					end else if (op.opc == OP_BRZ && dstat.a_zero) begin
						pc_q    <= PC_W'(EPI_BASE);
						state_q <= S_FETCH;
					end else begin
						pc_q    <= pc_adv;
						state_q <= S_FETCH;
					end
				end
				S_DIVW: if (dstat.div_done) state_q <= S_WBACK;
				S_WBACK: begin
					pc_q    <= pc_adv;
					state_q <= S_FETCH;
				end
				S_FIN: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/dvk_dp.sv @@
// Datapath: register file, saturating adder, rounding multiplier, divider and result registers.
`default_nettype none

module dvk_dp
	import dvk_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  dp_cmd_t                      dcmd,
	output dp_stat_t                     dstat,
	input  wire logic                    cfg_valid,
	input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [DATA_W-1:0]       cfg_data,
	input  wire logic signed [DATA_W-1:0] meas_x,
	input  wire logic signed [DATA_W-1:0] meas_y,
	output logic signed [DATA_W-1:0]     pos_x,
	output logic signed [DATA_W-1:0]     pos_y,
	output logic [DATA_W-1:0]            var_x,
	output logic [DATA_W-1:0]            var_y
);

	localparam int NW = DATA_W + FRAC_BITS;
	localparam int PW = 2 * DATA_W + 1;

	logic [15:0]       decay_q;
	logic [DATA_W-1:0] qn_q, rn_q, ipv_q, ivv_q;

	logic [DATA_W-1:0]        mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]     vld_q;
	logic signed [DATA_W-1:0] rda_q, rdb_q;
	logic signed [DATA_W-1:0] mx_q, my_q;
	logic signed [DATA_W-1:0] res_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [DATA_W-1:0] stg_px_q, stg_py_q;
	logic [DATA_W-1:0]        stg_vx_q, stg_vy_q;
	logic signed [DATA_W-1:0] px_q, py_q;
	logic [DATA_W-1:0]        vx_q, vy_q;

	logic signed [DATA_W:0]   bm;
	logic signed [DATA_W-1:0] cval;
	logic signed [WIDE_W-1:0] rnd;
	logic signed [DATA_W-1:0] mul_res;
	logic signed [DATA_W-1:0] div_res;
	logic signed [DATA_W-1:0] wdata;
	logic                     div_done, div_neg;
	logic [NW-1:0]            div_quot;
	logic [NW-1:0]            lim_pos, lim_neg;

	function automatic logic signed [DATA_W-1:0] reg_q(input logic [DATA_W-1:0] r);
		return r[DATA_W-1] ? 32'sh7FFF_FFFF : $signed(r);
	endfunction

	dvk_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dcmd.div_go),
		.num    (rda_q),
		.den    (rdb_q),
		.done   (div_done),
		.neg    (div_neg),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= 16'd45875;
			qn_q    <= 32'd1638400;
			rn_q    <= 32'd131072;
			ipv_q   <= 32'd327680;
			ivv_q   <= 32'd1638400;
		end else if (cfg_valid) begin
			case (cfg_addr)
				CFG_DECAY: decay_q <= cfg_data[15:0];
				CFG_QN:    qn_q    <= cfg_data;
				CFG_RN:    rn_q    <= cfg_data;
				CFG_IPV:   ipv_q   <= cfg_data;
				CFG_IVV:   ivv_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (dcmd.op.cs)
			CS_MX:   cval = mx_q;
			CS_MY:   cval = my_q;
			CS_QN:   cval = reg_q(qn_q);
			CS_RN:   cval = reg_q(rn_q);
			CS_IPV:  cval = reg_q(ipv_q);
			CS_IVV:  cval = reg_q(ivv_q);
			default: cval = '0;
		endcase
	end

	assign bm = (dcmd.op.opc == OP_AMUL) ? $signed({17'd0, decay_q}) : {rdb_q[DATA_W-1], rdb_q};

	// Round half up, then floor shift and saturate.
	always_comb begin
		if (dcmd.op.opc == OP_AMUL) begin
			rnd = (WIDE_W'(prod_q) + (WIDE_W'(1) <<< 15)) >>> 16;
		end else begin
			rnd = (WIDE_W'(prod_q) + (WIDE_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		end
		mul_res = sat_w(rnd);
	end

	assign lim_pos = NW'(32'h7FFF_FFFF);
	assign lim_neg = NW'(33'h0_8000_0000);

	always_comb begin
		if (!div_neg) begin
			div_res = (div_quot > lim_pos) ? 32'sh7FFF_FFFF : $signed(div_quot[DATA_W-1:0]);
		end else begin
			div_res = (div_quot > lim_neg) ? 32'sh8000_0000 : -$signed(div_quot[DATA_W-1:0]);
		end
	end

	always_comb begin
		case (dcmd.op.opc)
			OP_MUL, OP_AMUL: wdata = mul_res;
			OP_DIV:          wdata = div_res;
			default:         wdata = res_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (dcmd.wb) begin
			vld_q[dcmd.op.wd] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.wb) mem_q[dcmd.op.wd] <= wdata;
		if (dcmd.rd) begin
			rda_q <= vld_q[dcmd.op.ra] ? $signed(mem_q[dcmd.op.ra]) : '0;
			rdb_q <= vld_q[dcmd.op.rb] ? $signed(mem_q[dcmd.op.rb]) : '0;
		end
		if (dcmd.cap) begin
			mx_q <= meas_x;
			my_q <= meas_y;
		end
		if (dcmd.ex) begin
			case (dcmd.op.opc)
				OP_LDC: res_q <= cval;
				OP_ADD: res_q <= sat_w(WIDE_W'(rda_q) + WIDE_W'(rdb_q));
				OP_SUB: res_q <= sat_w(WIDE_W'(rda_q) - WIDE_W'(rdb_q));
				OP_MUL, OP_AMUL: prod_q <= rda_q * bm;
				OP_OUTP: begin
					stg_px_q <= rda_q;
					stg_py_q <= rdb_q;
				end
				OP_OUTV: begin
					stg_vx_q <= rda_q[DATA_W-1] ? '0 : rda_q;
					stg_vy_q <= rdb_q[DATA_W-1] ? '0 : rdb_q;
				end
				default: res_q <= rda_q;
			endcase
		end
		if (dcmd.out_load) begin
			px_q <= stg_px_q;
			py_q <= stg_py_q;
			vx_q <= stg_vx_q;
			vy_q <= stg_vy_q;
		end
	end

	assign dstat.a_zero   = (rda_q == '0);
	assign dstat.div_done = div_done;

	assign pos_x = px_q;
	assign pos_y = py_q;
	assign var_x = vx_q;
	assign var_y = vy_q;

endmodule

`default_nettype wire

@@ hw/rtl/decaying_velocity_kalman_2d.sv @@
// Top level of the four-state decaying-velocity tracking filter for one 2-D point.
`default_nettype none

// This block tracks one point with a four-state filter (x, y, vx, vy) in signed fixed point
// with FRAC_BITS fraction bits, saturating on overflow. Each input transaction carries one
// command: init loads a position with zero velocity and a diagonal covariance, predict steps
// the model with velocity decay and adds process noise, and update folds in a measured
// position. Every command, including the unused code, returns exactly one output transaction
// with the position and the two position variances. Commands run one at a time on a micro-
// programmed datapath with a single register file, one multiplier and one divider; each
// micro-operation is fetched and then executed, followed by a write-back when it writes a
// register; a division waits on the iterative divider before its write-back, and update
// runs eight such gain divisions. A finished result is held in an output register, so the
// next command may be accepted while the previous result still waits to be taken. The
// configuration port is always ready and must only be written while no command is in flight.
module decaying_velocity_kalman_2d
	import dvk_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [DATA_W-1:0]        cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               cmd,
	input  wire logic signed [DATA_W-1:0] meas_x,
	input  wire logic signed [DATA_W-1:0] meas_y,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      pos_x,
	output logic signed [DATA_W-1:0]      pos_y,
	output logic [DATA_W-1:0]             var_x,
	output logic [DATA_W-1:0]             var_y
);

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	// Configuration writes never stall.
	assign cfg_ready = 1'b1;

	dvk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dcmd      (dcmd),
		.dstat     (dstat)
	);

	dvk_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dcmd      (dcmd),
		.dstat     (dstat),
		.cfg_valid (cfg_valid),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.meas_x    (meas_x),
		.meas_y    (meas_y),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.var_x     (var_x),
		.var_y     (var_y)
	);

	// Once a command is taken the block is busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again right after a command was taken");

	// A fresh division never reports completion on the cycle after it starts.
	a_div_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.div_go |=> !dstat.div_done)
		else $error("divider reported done immediately after start");

	// Loading the result register always presents a result.
	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.out_load |=> out_valid)
		else $error("result loaded but output not valid");

	// The register file is never read and written in the same cycle.
	a_rd_wb_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.wb |-> !dcmd.rd)
		else $error("register file read and write overlap");

endmodule

`default_nettype wire
